>>> hdl/swarq_pkg.sv
// Shared types, constants and helpers of the sliding-window ARQ controller.
`default_nettype none

package swarq_pkg;

  localparam int SEQ_BITS    = 3;
  localparam int WINDOW      = 4;
  localparam int SLOT_BITS   = $clog2(WINDOW);
  localparam int COUNT_BITS  = 16;
  localparam int BUF_BITS    = 3;
  localparam int MAX_RESULTS = 24;
  localparam int PTR_BITS    = $clog2(MAX_RESULTS + 1);
  localparam int IDX_BITS    = $clog2(MAX_RESULTS);

  typedef enum logic [2:0] {
    FN_SEND_READY = 3'd0,
    FN_ARRIVAL    = 3'd1,
    FN_TIMEOUT    = 3'd2,
    FN_CKSUM_ERR  = 3'd3,
    FN_ACK_TMO    = 3'd4,
    FN_RESTART    = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_NAK  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CMD_FETCH      = 3'd0,
    CMD_TRANSMIT   = 3'd1,
    CMD_START_TMR  = 3'd2,
    CMD_STOP_TMR   = 3'd3,
    CMD_START_ACKT = 3'd4,
    CMD_STOP_ACKT  = 3'd5,
    CMD_STORE      = 3'd6
  } cmd_t;

  // Configuration register indexes
  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_TOTAL = 1'b1;

  localparam logic MODE_SR  = 1'b0;
  localparam logic MODE_GBN = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_SF_TX, ST_SF_TIMER, ST_SF_STOPACK, ST_SEND_END,
    ST_SR_DATA, ST_SR_STORE, ST_SR_DELIV, ST_SR_ACKT, ST_SR_NAK, ST_ACK_LOOP,
    ST_ARR_END, ST_CHECK, ST_GBN_ARR, ST_GBN_DEL, ST_GBN_ACK, ST_GBN_TO_LOOP,
    ST_GBN_TO_NEXT, ST_FINISH, ST_DRAIN
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_RESTART, OP_SEND_FETCH, OP_SEND_END, OP_SF_TX,
    OP_SF_TIMER, OP_SF_STOPACK, OP_SR_NAK0, OP_SR_INORDER, OP_SR_STORE,
    OP_SR_DELIVER, OP_EMIT_ACKT, OP_SF_SET_RESEND, OP_ACK_STEP, OP_CHECK,
    OP_SF_SET_TOS, OP_SF_SET_NAK, OP_SF_SET_ACK, OP_GBN_STORE, OP_GBN_DELIVER,
    OP_GBN_TO_INIT, OP_GBN_TO_SET, OP_GBN_TO_NEXT, OP_LOAD_OUT
  } op_t;

  // Status from datapath to controller
  typedef struct packed {
    func_t func;
    kind_t kind;
    logic  mode;
    logic  nak_allowed;
    logic  out_of_order;
    logic  seq_eq;
    logic  store_ok;
    logic  deliver_ok;
    logic  resend_ok;
    logic  ack_ok;
    logic  sf_data;
    logic  last_slot;
    logic  rem_zero;
    logic  out_free;
    logic  drain_last;
    logic  buf_empty;
  } dp_status_t;

  // One buffered command
  typedef struct packed {
    cmd_t                 cmd;
    kind_t                kind;
    logic [SEQ_BITS-1:0]  seq;
    logic [SEQ_BITS-1:0]  ack;
    logic [SLOT_BITS-1:0] slot;
    logic                 dflag;
  } entry_t;

  // Circular test a <= b < c
  function automatic logic between(input logic [SEQ_BITS-1:0] a,
                                   input logic [SEQ_BITS-1:0] b,
                                   input logic [SEQ_BITS-1:0] c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

endpackage

`default_nettype wire

>>> hdl/sliding_window_arq_controller.sv
// Top level of the sliding-window ARQ controller: ports and packing.
//
// Channel  Direction  Signals                     Contents
// s_*      in         tvalid tready tdata tuser   one event per transaction
// m_*      out        tvalid tready tdata tuser   one command per transaction
//                     tlast                       last command of an event
// cfg_*    in         valid ready index data      register write
//
// An event is latched and dispatched, then the controller runs one step per
// command plus decision steps that emit nothing (two more per frame of a
// go-back-N resend), one finishing step, then drains one command at a time
// out of the buffer.
// Synchronous reset returns window state and configuration to defaults.
// A stalled m_tready holds the drain; s_tready is high only when idle.
`default_nettype none

module sliding_window_arq_controller (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // frame_seq, frame_ack, timed_out_seq
  input  wire logic [4:0]  s_tuser,   // func, frame_kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // seq_number, ack_number, slot, done_res, may_send
  output logic [5:0]       m_tuser,   // command, tx_kind, deliver_flag
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);
  import swarq_pkg::*;

  op_t        op;
  dp_status_t status;
  entry_t     out_entry;
  logic       out_done;
  logic       out_may;

  assign cfg_ready = 1'b1;

  swarq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .op       (op)
  );

  swarq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .status    (status),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_func   (s_tuser[2:0]),
    .in_kind   (s_tuser[4:3]),
    .in_seq    (s_tdata[2:0]),
    .in_ack    (s_tdata[5:3]),
    .in_tos    (s_tdata[8:6]),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_entry (out_entry),
    .out_last  (m_tlast),
    .out_done  (out_done),
    .out_may   (out_may)
  );

  // Pack result fields
  assign m_tdata = {6'd0, out_may, out_done, out_entry.slot, out_entry.ack, out_entry.seq};
  assign m_tuser = {out_entry.dflag, out_entry.kind, out_entry.cmd};

endmodule

`default_nettype wire

>>> hdl/swarq_dp.sv
// Datapath: window state, counters, command buffer and output register.
`default_nettype none

module swarq_dp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire swarq_pkg::op_t                  op,
  output swarq_pkg::dp_status_t                status,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [15:0]                     cfg_data,
  input  wire logic [2:0]                      in_func,
  input  wire logic [1:0]                      in_kind,
  input  wire logic [swarq_pkg::SEQ_BITS-1:0]  in_seq,
  input  wire logic [swarq_pkg::SEQ_BITS-1:0]  in_ack,
  input  wire logic [swarq_pkg::SEQ_BITS-1:0]  in_tos,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output swarq_pkg::entry_t                    out_entry,
  output logic                                 out_last,
  output logic                                 out_done,
  output logic                                 out_may
);
  import swarq_pkg::*;

  // Configuration
  logic                  mode;
  logic [15:0]           total_frames;

  // Latched event
  func_t                 ev_func;
  kind_t                 ev_kind;
  logic [SEQ_BITS-1:0]   ev_seq;
  logic [SEQ_BITS-1:0]   ev_ack;
  logic [SEQ_BITS-1:0]   ev_tos;

  // Window state
  logic [SEQ_BITS-1:0]   ack_expected_seq;
  logic [SEQ_BITS-1:0]   next_send_seq;
  logic [SEQ_BITS-1:0]   expected_rx_seq;
  logic [SEQ_BITS-1:0]   rx_window_top;
  logic [BUF_BITS-1:0]   buffered_count;
  logic [WINDOW-1:0]     arrived_marks;
  logic                  nak_allowed;
  logic                  out_of_order;
  logic                  transfer_done;
  logic [COUNT_BITS-1:0] received_count;
  logic [COUNT_BITS-1:0] sent_count;

  // Frame under transmission and retransmit counter
  kind_t                 sf_kind;
  logic [SEQ_BITS-1:0]   sf_seq;
  logic [BUF_BITS-1:0]   rem;

  // Command buffer
  entry_t                mem [MAX_RESULTS];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;

  logic                  emit;
  entry_t                emit_entry;
  logic [SEQ_BITS-1:0]   ack_plus;
  logic                  may_now;

  assign ack_plus = ev_ack + SEQ_BITS'(1);
  assign may_now  = (32'(buffered_count) < WINDOW) &&
                    (sent_count < COUNT_BITS'(total_frames));

  // Status toward controller
  always_comb begin
    status.func         = ev_func;
    status.kind         = ev_kind;
    status.mode         = mode;
    status.nak_allowed  = nak_allowed;
    status.out_of_order = out_of_order;
    status.seq_eq       = (ev_seq == expected_rx_seq);
    status.store_ok     = between(expected_rx_seq, ev_seq, rx_window_top) &&
                          !arrived_marks[ev_seq[SLOT_BITS-1:0]];
    status.deliver_ok   = arrived_marks[expected_rx_seq[SLOT_BITS-1:0]];
    status.resend_ok    = between(ack_expected_seq, ack_plus, next_send_seq);
    status.ack_ok       = between(ack_expected_seq, ev_ack, next_send_seq);
    status.sf_data      = (sf_kind == KIND_DATA);
    status.last_slot    = (ev_seq[SLOT_BITS-1:0] == SLOT_BITS'(WINDOW - 1));
    status.rem_zero     = (rem == '0);
    status.out_free     = !out_valid || out_ready;
    status.drain_last   = (rd_ptr == wr_ptr - PTR_BITS'(1));
    status.buf_empty    = (wr_ptr == '0);
  end

  // Select the command written to the buffer
  always_comb begin
    emit       = 1'b0;
    emit_entry = '0;
    case (op)
      OP_SEND_FETCH: begin
        emit           = 1'b1;
        emit_entry.cmd = CMD_FETCH;
        emit_entry.seq = next_send_seq;
        emit_entry.slot = next_send_seq[SLOT_BITS-1:0];
      end
      OP_SF_TX: begin
        emit            = 1'b1;
        emit_entry.cmd  = CMD_TRANSMIT;
        emit_entry.kind = sf_kind;
        emit_entry.seq  = sf_seq;
        emit_entry.ack  = expected_rx_seq - SEQ_BITS'(1);
        emit_entry.slot = sf_seq[SLOT_BITS-1:0];
      end
      OP_SF_TIMER: begin
        emit           = 1'b1;
        emit_entry.cmd = CMD_START_TMR;
        emit_entry.seq = sf_seq;
      end
      OP_SF_STOPACK: begin
        emit           = 1'b1;
        emit_entry.cmd = CMD_STOP_ACKT;
      end
      OP_SR_INORDER, OP_EMIT_ACKT: begin
        emit           = 1'b1;
        emit_entry.cmd = CMD_START_ACKT;
      end
      OP_SR_STORE, OP_GBN_STORE, OP_GBN_DELIVER: begin
        emit             = 1'b1;
        emit_entry.cmd   = CMD_STORE;
        emit_entry.seq   = ev_seq;
        emit_entry.slot  = ev_seq[SLOT_BITS-1:0];
        emit_entry.dflag = (op == OP_GBN_DELIVER);
      end
      OP_SR_DELIVER: begin
        emit             = 1'b1;
        emit_entry.cmd   = CMD_STORE;
        emit_entry.seq   = expected_rx_seq;
        emit_entry.slot  = expected_rx_seq[SLOT_BITS-1:0];
        emit_entry.dflag = 1'b1;
      end
      OP_ACK_STEP: begin
        emit           = 1'b1;
        emit_entry.cmd = CMD_STOP_TMR;
        emit_entry.seq = ack_expected_seq;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_SR;
      total_frames <= 16'd1;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MODE) begin
        mode <= cfg_data[0];
      end else begin
        total_frames <= cfg_data;
      end
    end
  end

  // Latch the event fields
  always_ff @(posedge clk) begin
    if (op == OP_LATCH) begin
      ev_func <= func_t'(in_func);
      ev_kind <= kind_t'(in_kind);
      ev_seq  <= in_seq;
      ev_ack  <= in_ack;
      ev_tos  <= in_tos;
    end
  end

  // Frame to send and retransmit count
  always_ff @(posedge clk) begin
    case (op)
      OP_SEND_FETCH, OP_GBN_TO_SET: begin
        sf_kind <= KIND_DATA;
        sf_seq  <= next_send_seq;
      end
      OP_SR_NAK0, OP_SF_SET_NAK: begin
        sf_kind <= KIND_NAK;
        sf_seq  <= '0;
      end
      OP_SF_SET_ACK: begin
        sf_kind <= KIND_ACK;
        sf_seq  <= '0;
      end
      OP_SF_SET_RESEND: begin
        sf_kind <= KIND_DATA;
        sf_seq  <= ack_plus;
      end
      OP_SF_SET_TOS: begin
        sf_kind <= KIND_DATA;
        sf_seq  <= ev_tos;
      end
      default: begin
        sf_kind <= sf_kind;
      end
    endcase
    if (op == OP_GBN_TO_INIT) begin
      rem <= buffered_count;
    end else if (op == OP_GBN_TO_NEXT) begin
      rem <= rem - BUF_BITS'(1);
    end
  end

  // Window state updates
  always_ff @(posedge clk) begin
    if (rst || op == OP_RESTART) begin
      ack_expected_seq <= '0;
      next_send_seq    <= '0;
      expected_rx_seq  <= '0;
      rx_window_top    <= SEQ_BITS'(WINDOW);
      buffered_count   <= '0;
      arrived_marks    <= '0;
      nak_allowed      <= 1'b1;
      out_of_order     <= 1'b0;
      transfer_done    <= 1'b0;
      received_count   <= '0;
      sent_count       <= '0;
    end else begin
      case (op)
        OP_SEND_FETCH: begin
          buffered_count <= buffered_count + BUF_BITS'(1);
        end
        OP_SEND_END: begin
          next_send_seq <= next_send_seq + SEQ_BITS'(1);
          sent_count    <= sent_count + COUNT_BITS'(1);
        end
        OP_SF_TX: begin
          if (sf_kind == KIND_NAK) begin
            nak_allowed <= 1'b0;
          end
        end
        OP_SR_NAK0: begin
          out_of_order <= 1'b1;
        end
        OP_SR_INORDER: begin
          out_of_order <= 1'b0;
        end
        OP_SR_STORE: begin
          arrived_marks[ev_seq[SLOT_BITS-1:0]] <= 1'b1;
        end
        OP_SR_DELIVER: begin
          nak_allowed     <= 1'b1;
          arrived_marks[expected_rx_seq[SLOT_BITS-1:0]] <= 1'b0;
          expected_rx_seq <= expected_rx_seq + SEQ_BITS'(1);
          rx_window_top   <= rx_window_top + SEQ_BITS'(1);
          received_count  <= received_count + COUNT_BITS'(1);
        end
        OP_GBN_DELIVER: begin
          expected_rx_seq <= expected_rx_seq + SEQ_BITS'(1);
          received_count  <= received_count + COUNT_BITS'(1);
        end
        OP_ACK_STEP: begin
          buffered_count   <= buffered_count - BUF_BITS'(1);
          ack_expected_seq <= ack_expected_seq + SEQ_BITS'(1);
          received_count   <= received_count + COUNT_BITS'(1);
        end
        OP_CHECK: begin
          if (received_count == COUNT_BITS'(total_frames)) begin
            transfer_done <= 1'b1;
          end
        end
        OP_GBN_TO_INIT: begin
          next_send_seq <= ack_expected_seq;
        end
        OP_GBN_TO_NEXT: begin
          next_send_seq <= next_send_seq + SEQ_BITS'(1);
        end
        default: begin
          nak_allowed <= nak_allowed;
        end
      endcase
    end
  end

  // Buffer pointers; drop commands past the buffer depth
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else if (op == OP_LATCH) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (emit && (32'(wr_ptr) < MAX_RESULTS)) begin
        wr_ptr <= wr_ptr + PTR_BITS'(1);
      end
      if (op == OP_LOAD_OUT) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
    end
  end

  // Buffer write
  always_ff @(posedge clk) begin
    if (emit && (32'(wr_ptr) < MAX_RESULTS)) begin
      mem[wr_ptr[IDX_BITS-1:0]] <= emit_entry;
    end
  end

  // Output register, loaded by registered buffer read
  always_ff @(posedge clk) begin
    if (op == OP_LOAD_OUT) begin
      out_entry <= mem[rd_ptr[IDX_BITS-1:0]];
      out_last  <= status.drain_last;
      out_done  <= transfer_done;
      out_may   <= may_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_LOAD_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> hdl/swarq_ctrl.sv
// Controller: sequences the micro-operations of one event and the drain.
`default_nettype none

module swarq_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire swarq_pkg::dp_status_t status,
  output swarq_pkg::op_t             op
);
  import swarq_pkg::*;

  state_t state, state_next;
  state_t ret_state, ret_state_next;
  logic   need_check;

  // Decide whether an arrival ends with the end-of-transfer check
  always_comb begin
    if (status.mode == MODE_GBN) begin
      need_check = 1'b1;
    end else if (status.kind == KIND_DATA) begin
      need_check = status.out_of_order;
    end else begin
      need_check = (status.kind == KIND_ACK) || (status.kind == KIND_NAK);
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret_state <= ST_FINISH;
    end else begin
      state     <= state_next;
      ret_state <= ret_state_next;
    end
  end

  // Next state and operation
  always_comb begin
    state_next     = state;
    ret_state_next = ret_state;
    op             = OP_NONE;
    in_ready       = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op         = OP_LATCH;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_next = ST_FINISH;
        case (status.func)
          FN_RESTART: begin
            op = OP_RESTART;
          end
          FN_SEND_READY: begin
            op             = OP_SEND_FETCH;
            ret_state_next = ST_SEND_END;
            state_next     = ST_SF_TX;
          end
          FN_ARRIVAL: begin
            state_next = (status.mode == MODE_GBN) ? ST_GBN_ARR : ST_SR_DATA;
          end
          FN_TIMEOUT: begin
            if (status.mode == MODE_GBN) begin
              op         = OP_GBN_TO_INIT;
              state_next = ST_GBN_TO_LOOP;
            end else begin
              op             = OP_SF_SET_TOS;
              ret_state_next = ST_FINISH;
              state_next     = ST_SF_TX;
            end
          end
          FN_CKSUM_ERR: begin
            if (status.mode == MODE_SR && status.nak_allowed) begin
              op             = OP_SF_SET_NAK;
              ret_state_next = ST_CHECK;
              state_next     = ST_SF_TX;
            end
          end
          FN_ACK_TMO: begin
            if (status.mode == MODE_SR) begin
              op             = OP_SF_SET_ACK;
              ret_state_next = ST_CHECK;
              state_next     = ST_SF_TX;
            end
          end
          default: begin
            state_next = ST_FINISH;
          end
        endcase
      end
      ST_SF_TX: begin
        op         = OP_SF_TX;
        state_next = status.sf_data ? ST_SF_TIMER : ST_SF_STOPACK;
      end
      ST_SF_TIMER: begin
        op         = OP_SF_TIMER;
        state_next = ST_SF_STOPACK;
      end
      ST_SF_STOPACK: begin
        op         = OP_SF_STOPACK;
        state_next = ret_state;
      end
      ST_SEND_END: begin
        op         = OP_SEND_END;
        state_next = ST_FINISH;
      end
      ST_SR_DATA: begin
        if (status.kind != KIND_DATA) begin
          state_next = ST_SR_NAK;
        end else if (!status.seq_eq) begin
          if (status.nak_allowed) begin
            op             = OP_SR_NAK0;
            ret_state_next = ST_SR_STORE;
            state_next     = ST_SF_TX;
          end else begin
            state_next = ST_SR_STORE;
          end
        end else begin
          op         = OP_SR_INORDER;
          state_next = ST_SR_STORE;
        end
      end
      ST_SR_STORE: begin
        if (status.store_ok) begin
          op         = OP_SR_STORE;
          state_next = ST_SR_DELIV;
        end else begin
          state_next = ST_SR_NAK;
        end
      end
      ST_SR_DELIV: begin
        if (status.deliver_ok) begin
          op         = OP_SR_DELIVER;
          state_next = ST_SR_ACKT;
        end else begin
          state_next = ST_SR_NAK;
        end
      end
      ST_SR_ACKT: begin
        op         = OP_EMIT_ACKT;
        state_next = ST_SR_DELIV;
      end
      ST_SR_NAK: begin
        if (status.kind == KIND_NAK && status.resend_ok) begin
          op             = OP_SF_SET_RESEND;
          ret_state_next = ST_ACK_LOOP;
          state_next     = ST_SF_TX;
        end else begin
          state_next = ST_ACK_LOOP;
        end
      end
      ST_ACK_LOOP: begin
        if (status.ack_ok) begin
          op = OP_ACK_STEP;
        end else begin
          state_next = ST_ARR_END;
        end
      end
      ST_ARR_END: begin
        if (need_check) begin
          op = OP_CHECK;
        end
        state_next = ST_FINISH;
      end
      ST_CHECK: begin
        op         = OP_CHECK;
        state_next = ST_FINISH;
      end
      ST_GBN_ARR: begin
        if (status.seq_eq) begin
          op         = OP_GBN_STORE;
          state_next = ST_GBN_DEL;
        end else begin
          state_next = ST_ACK_LOOP;
        end
      end
      ST_GBN_DEL: begin
        op         = OP_GBN_DELIVER;
        state_next = status.last_slot ? ST_GBN_ACK : ST_ACK_LOOP;
      end
      ST_GBN_ACK: begin
        op             = OP_SF_SET_ACK;
        ret_state_next = ST_ACK_LOOP;
        state_next     = ST_SF_TX;
      end
      ST_GBN_TO_LOOP: begin
        if (!status.rem_zero) begin
          op             = OP_GBN_TO_SET;
          ret_state_next = ST_GBN_TO_NEXT;
          state_next     = ST_SF_TX;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_GBN_TO_NEXT: begin
        op         = OP_GBN_TO_NEXT;
        state_next = ST_GBN_TO_LOOP;
      end
      ST_FINISH: begin
        state_next = status.buf_empty ? ST_IDLE : ST_DRAIN;
      end
      ST_DRAIN: begin
        if (status.out_free) begin
          op = OP_LOAD_OUT;
          if (status.drain_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
